FILE: rtl/chu_pkg.sv
// ----------------------------------------------------------------------------
// chu_pkg
// Shared constants for the compass heading unwrap unit. Angles are in
// 1/32-degree units.
// ----------------------------------------------------------------------------
package chu_pkg;

	localparam int BearingW  = 8;
	localparam int OffsetW   = 15;
	localparam int FineW     = 14;
	localparam int DegW      = 9;
	localparam int DirW      = 3;
	localparam int ContW     = 30;
	localparam int DeltaW    = 16;
	localparam int TurnW     = 16;
	localparam int SumW      = 18;

	localparam int FullTurn  = 11520;
	localparam int HighEdge  = 9600;
	localparam int LowEdge   = 1920;
	localparam int StepScale = 45;
	localparam int HalfDeg   = 16;
	localparam int DegTurn   = 360;

	localparam logic signed [TurnW-1:0] TurnMax = 16'sh7FFF;
	localparam logic signed [TurnW-1:0] TurnMin = 16'sh8000;

	localparam logic [DirW-1:0] DirN  = 3'd0;
	localparam logic [DirW-1:0] DirNe = 3'd1;
	localparam logic [DirW-1:0] DirE  = 3'd2;
	localparam logic [DirW-1:0] DirSe = 3'd3;
	localparam logic [DirW-1:0] DirS  = 3'd4;
	localparam logic [DirW-1:0] DirSw = 3'd5;
	localparam logic [DirW-1:0] DirW_ = 3'd6;
	localparam logic [DirW-1:0] DirNw = 3'd7;

	localparam logic CmdSample = 1'b0;
	localparam logic CmdClear  = 1'b1;

	function automatic logic [DirW-1:0] sector_of(input logic [DegW-1:0] deg);
		logic [DirW-1:0] s;
		if (deg >= 9'd23 && deg < 9'd68) begin
			s = DirNe;
		end else if (deg >= 9'd68 && deg < 9'd113) begin
			s = DirE;
		end else if (deg >= 9'd113 && deg < 9'd158) begin
			s = DirSe;
		end else if (deg >= 9'd158 && deg < 9'd203) begin
			s = DirS;
		end else if (deg >= 9'd203 && deg < 9'd248) begin
			s = DirSw;
		end else if (deg >= 9'd248 && deg < 9'd293) begin
			s = DirW_;
		end else if (deg >= 9'd293 && deg < 9'd338) begin
			s = DirNw;
		end else begin
			s = DirN;
		end
		return s;
	endfunction

endpackage

FILE: rtl/compass_heading_unwrap_unit.sv
// ----------------------------------------------------------------------------
// compass_heading_unwrap_unit
// Scales an 8-bit compass bearing to a fine heading, applies the offset,
// wraps it to one turn and unwraps it into a continuous angle.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  s_*       in         s_tvalid, s_tready, s_tdata, s_tuser
//  m_*       out        m_tvalid, m_tready, m_tdata, m_tuser
//  cfg_*     in         cfg_valid, cfg_ready, cfg_data (heading offset)
//
// One word per cycle while m_tready is high; a word passes through the input
// register and then the result register.
// Reset clears the offset, the tracking state and both valid flags.
// A stalled result holds in the result register while the input register
// still takes one more word; s_tready then falls until m_tready returns.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module compass_heading_unwrap_unit import chu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // bearing[7:0]
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // heading_fine[13:0], heading_deg[22:14],
	                               // direction[25:23], continuous_heading[55:26],
	                               // heading_delta[71:56]
	output logic        m_tuser,   // first_sample
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	logic                           valid_s1;
	logic                           cmd_s1;
	logic [BearingW-1:0]            bearing_s1;
	logic                           valid_s2;
	logic [FineW-1:0]               fine_s2;
	logic [DegW-1:0]                deg_s2;
	logic [DirW-1:0]                dir_s2;
	logic signed [ContW-1:0]        cont_s2;
	logic signed [DeltaW-1:0]       delta_s2;
	logic                           first_s2;

	logic signed [OffsetW-1:0]      offset_q;
	logic                           have_q;
	logic [FineW-1:0]               prev_q;
	logic signed [ContW-1:0]        base_q;
	logic signed [TurnW-1:0]        turn_q;

	logic                           advance;
	logic [FineW-1:0]               prod;
	logic signed [SumW-1:0]         sum;
	logic signed [SumW-1:0]         wrapped;
	logic [FineW-1:0]               fine;
	logic [DegW:0]                  deg_wide;
	logic [DegW-1:0]                deg;
	logic                           up;
	logic                           down;
	logic signed [ContW-1:0]        base_next;
	logic signed [ContW-1:0]        cont;
	logic signed [DeltaW-1:0]       diff;
	logic signed [DeltaW-1:0]       delta;

	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_comb begin
		prod = FineW'({{(FineW-BearingW){1'b0}}, bearing_s1} * FineW'(StepScale));
		sum  = $signed({{(SumW-FineW){1'b0}}, prod})
			+ $signed({{(SumW-OffsetW){offset_q[OffsetW-1]}}, offset_q});
		if (sum < -SumW'(FullTurn)) begin
			wrapped = sum + SumW'(2 * FullTurn);
		end else if (sum < 0) begin
			wrapped = sum + SumW'(FullTurn);
		end else if (sum < SumW'(FullTurn)) begin
			wrapped = sum;
		end else if (sum < SumW'(2 * FullTurn)) begin
			wrapped = sum - SumW'(FullTurn);
		end else begin
			wrapped = sum - SumW'(2 * FullTurn);
		end
		fine = wrapped[FineW-1:0];

		deg_wide = (DegW+1)'(({1'b0, fine} + (FineW+1)'(HalfDeg)) >> 5);
		deg = (deg_wide == (DegW+1)'(DegTurn)) ? '0 : deg_wide[DegW-1:0];

		up   = have_q && (prev_q > FineW'(HighEdge)) && (fine < FineW'(LowEdge))
			&& (turn_q != TurnMax);
		down = have_q && (prev_q < FineW'(LowEdge)) && (fine > FineW'(HighEdge))
			&& (turn_q != TurnMin);

		if (up) begin
			base_next = base_q + ContW'(FullTurn);
		end else if (down) begin
			base_next = base_q - ContW'(FullTurn);
		end else begin
			base_next = base_q;
		end
		cont = base_next + $signed({{(ContW-FineW){1'b0}}, fine});

		diff = $signed({{(DeltaW-FineW){1'b0}}, fine})
			- $signed({{(DeltaW-FineW){1'b0}}, prev_q});
		if (up) begin
			delta = diff + DeltaW'(FullTurn);
		end else if (down) begin
			delta = diff - DeltaW'(FullTurn);
		end else begin
			delta = diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= s_tuser;
			bearing_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			have_q   <= 1'b0;
			prev_q   <= '0;
			base_q   <= '0;
			turn_q   <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				if (cmd_s1 == CmdClear) begin
					have_q <= 1'b0;
					prev_q <= '0;
					base_q <= '0;
					turn_q <= '0;
				end else if (!have_q) begin
					have_q <= 1'b1;
					prev_q <= fine;
					base_q <= '0;
					turn_q <= '0;
				end else begin
					prev_q <= fine;
					base_q <= base_next;
					if (up) begin
						turn_q <= turn_q + TurnW'(1);
					end else if (down) begin
						turn_q <= turn_q - TurnW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (cmd_s1 == CmdClear) begin
				fine_s2  <= '0;
				deg_s2   <= '0;
				dir_s2   <= DirN;
				cont_s2  <= '0;
				delta_s2 <= '0;
				first_s2 <= 1'b0;
			end else if (!have_q) begin
				fine_s2  <= fine;
				deg_s2   <= deg;
				dir_s2   <= sector_of(deg);
				cont_s2  <= $signed({{(ContW-FineW){1'b0}}, fine});
				delta_s2 <= '0;
				first_s2 <= 1'b1;
			end else begin
				fine_s2  <= fine;
				deg_s2   <= deg;
				dir_s2   <= sector_of(deg);
				cont_s2  <= cont;
				delta_s2 <= delta;
				first_s2 <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {delta_s2, cont_s2, dir_s2, deg_s2, fine_s2};
	assign m_tuser  = first_s2;

endmodule
